@@ hw/rtl/mexp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants of the modular exponentiation block: sequencer
// states, the multiply-reduce unit states and the register map.
// ----------------------------------------------------------------------------
package mexp_pkg;

   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   localparam logic [0:0] RegIdxModulus = 1'b0;

   localparam logic [31:0] ModulusReset = 32'hFFFF_FFFB;

   typedef enum logic [2:0] {
      S_IDLE,
      S_BASE,
      S_STEP,
      S_MUL,
      S_SQR,
      S_OUT
   } mexp_state_type;

   typedef enum logic [0:0] {
      MM_IDLE,
      MM_RED
   } mexp_mm_state_type;

endpackage : mexp_pkg
`default_nettype wire

@@ hw/rtl/mexp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_req_if / mexp_rsp_if
// Valid/ready channels that carry the request items (base and exponent) and
// the result items (power_mod) of the modular exponentiation block.
// ----------------------------------------------------------------------------
interface mexp_req_if #(
   parameter int MOD_WIDTH = 32,
   parameter int EXP_WIDTH = 64
);
   logic                 valid;
   logic                 ready;
   logic [MOD_WIDTH-1:0] base;
   logic [EXP_WIDTH-1:0] exponent;

   modport source (output valid, output base, output exponent, input ready);
   modport sink   (input valid, input base, input exponent, output ready);
endinterface : mexp_req_if

interface mexp_rsp_if #(
   parameter int MOD_WIDTH = 32
);
   logic                 valid;
   logic                 ready;
   logic [MOD_WIDTH-1:0] power_mod;

   modport source (output valid, output power_mod, input ready);
   modport sink   (input valid, input power_mod, output ready);
endinterface : mexp_rsp_if
`default_nettype wire

@@ hw/rtl/mexp_modmul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_modmul
// Shared multiply-reduce unit. The full product is registered first, then
// one restoring shift-subtract step per cycle reduces it modulo the modulus.
// A zero modulus acts as two to the power of the operand width.
// ----------------------------------------------------------------------------
module mexp_modmul #(
   parameter int MOD_WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [MOD_WIDTH-1:0] op_a,
   input  wire logic [MOD_WIDTH-1:0] op_b,
   input  wire logic [MOD_WIDTH-1:0] modulus,
   output logic                      done,
   output logic [MOD_WIDTH-1:0]      result
);
   import mexp_pkg::*;

   localparam int CntWidth = $clog2(MOD_WIDTH);
   localparam logic [CntWidth-1:0] CntLast = CntWidth'(MOD_WIDTH - 1);

   mexp_mm_state_type      state_ff, state_in;
   logic [CntWidth-1:0]    cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic [MOD_WIDTH:0]     rem_ff, rem_in;
   logic [MOD_WIDTH-1:0]   low_ff, low_in;

   logic [2*MOD_WIDTH-1:0] product;
   logic [MOD_WIDTH:0]     mod_eff;
   logic [MOD_WIDTH:0]     shifted;
   logic [MOD_WIDTH:0]     diff;

   assign product = op_a * op_b;
   assign mod_eff = {(modulus == '0), modulus};
   assign shifted = {rem_ff[MOD_WIDTH-1:0], low_ff[MOD_WIDTH-1]};
   assign diff    = shifted - mod_eff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MM_IDLE: begin
            if (start) begin
               state_in = MM_RED;
            end
         end
         MM_RED: begin
            if (cnt_ff == CntLast) begin
               state_in = MM_IDLE;
            end
         end
         default: begin
            state_in = MM_IDLE;
         end
      endcase
   end

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      unique case (state_ff)
         MM_IDLE: begin
            if (start) begin
               rem_in = {1'b0, product[2*MOD_WIDTH-1:MOD_WIDTH]};
               low_in = product[MOD_WIDTH-1:0];
               cnt_in = '0;
            end
         end
         MM_RED: begin
            rem_in  = (shifted >= mod_eff) ? diff : shifted;
            low_in  = {low_ff[MOD_WIDTH-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            done_in = (cnt_ff == CntLast);
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MM_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
   end

   assign done   = done_ff;
   assign result = rem_ff[MOD_WIDTH-1:0];

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == MM_IDLE)
      else $error("Multiply-reduce unit started while busy.");

   a_done_after_last_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == MM_RED && cnt_ff == CntLast) |=> done_ff)
      else $error("Multiply-reduce unit missed its done pulse.");

   a_done_in_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == MM_IDLE)
      else $error("Multiply-reduce unit signaled done while still reducing.");

endmodule : mexp_modmul
`default_nettype wire

@@ hw/rtl/modular_exponentiation.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply exponentiation modulo a programmable
// modulus, built around one shared multiply-reduce unit.
//
// A request item carries base and exponent; each one yields one result item
// with power_mod, which is base to the exponent modulo the modulus, or 1
// when the exponent is zero. The modulus register sits at address 0 of the
// APB port and resets to 4294967291; write it only while the block is idle.
// Every multiply-reduce operation registers the product, then performs
// MOD_WIDTH restoring subtract steps, and its result is captured. An item
// costs one operation to reduce the base, one square per exponent bit below
// the highest set bit, and one multiply per set bit, so at most 2 * EXP_WIDTH
// operations per item.
// The block takes a new item only when the previous one is finished; the
// finished result waits in an output register, so a stalled receiver holds
// back at most the following item. Reset empties the output register and
// returns the sequencer to idle.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
   parameter int MOD_WIDTH = 32,
   parameter int EXP_WIDTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   mexp_req_if.sink         req_chan,
   mexp_rsp_if.source       rsp_chan,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import mexp_pkg::*;

   mexp_state_type        state_ff, state_in;
   logic [MOD_WIDTH-1:0]  modulus_ff;
   logic [MOD_WIDTH-1:0]  base_ff, base_in;
   logic [MOD_WIDTH-1:0]  acc_ff, acc_in;
   logic [EXP_WIDTH-1:0]  exp_ff, exp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MOD_WIDTH-1:0]  rsp_data_ff, rsp_data_in;

   logic                  csr_write;
   logic                  req_ready;
   logic                  out_free;
   logic                  mm_start;
   logic [MOD_WIDTH-1:0]  mm_a;
   logic [MOD_WIDTH-1:0]  mm_b;
   logic                  mm_done;
   logic [MOD_WIDTH-1:0]  mm_result;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[2:2] == RegIdxModulus);

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= ModulusReset[MOD_WIDTH-1:0];
      end else if (csr_write) begin
         modulus_ff <= pwdata[MOD_WIDTH-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2:2] == RegIdxModulus) begin
         prdata = CsrDataWidth'(modulus_ff);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               state_in = S_BASE;
            end
         end
         S_BASE, S_MUL, S_SQR: begin
            if (mm_done) begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (exp_ff == '0) begin
               state_in = S_OUT;
            end else if (exp_ff[0]) begin
               state_in = S_MUL;
            end else begin
               state_in = S_SQR;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      mm_start     = 1'b0;
      mm_a         = base_ff;
      mm_b         = base_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      exp_in       = exp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            mm_a      = req_chan.base;
            mm_b      = MOD_WIDTH'(1);
            if (req_chan.valid) begin
               mm_start = 1'b1;
               acc_in   = MOD_WIDTH'(1);
               exp_in   = req_chan.exponent;
            end
         end
         S_BASE: begin
            if (mm_done) begin
               base_in = mm_result;
            end
         end
         S_STEP: begin
            mm_a = exp_ff[0] ? acc_ff : base_ff;
            if (exp_ff != '0) begin
               mm_start = 1'b1;
            end
         end
         S_MUL: begin
            if (mm_done) begin
               acc_in = mm_result;
               exp_in = {exp_ff[EXP_WIDTH-1:1], 1'b0};
            end
         end
         S_SQR: begin
            if (mm_done) begin
               base_in = mm_result;
               exp_in  = exp_ff >> 1;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      acc_ff      <= acc_in;
      exp_ff      <= exp_in;
      rsp_data_ff <= rsp_data_in;
   end

   mexp_modmul #(
      .MOD_WIDTH (MOD_WIDTH)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .op_a    (mm_a),
      .op_b    (mm_b),
      .modulus (modulus_ff),
      .done    (mm_done),
      .result  (mm_result)
   );

   assign req_chan.ready     = req_ready;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.power_mod = rsp_data_ff;

   a_done_while_waiting: assert property (@(posedge clock) disable iff (reset)
      mm_done |-> (state_ff == S_BASE || state_ff == S_MUL || state_ff == S_SQR))
      else $error("Multiply-reduce result arrived while no operation was pending.");

   a_square_shifts_exponent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQR && mm_done) |=> exp_ff == ($past(exp_ff) >> 1))
      else $error("Exponent did not advance after a square.");

   a_result_from_out_state: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("Result item presented outside the output step.");

endmodule : modular_exponentiation
`default_nettype wire
